### sv/alfp_pkg.sv
package alfp_pkg;

    localparam int MaxFields = 7;
    localparam int FieldW    = 18;
    localparam int MagW      = 17;
    localparam int DataW     = 104;
    localparam int PrefixLen = 4;

    localparam logic [7:0]     ChA     = 8'h41;
    localparam logic [7:0]     ChI     = 8'h49;
    localparam logic [7:0]     ChM     = 8'h4D;
    localparam logic [7:0]     ChComma = 8'h2C;
    localparam logic [7:0]     ChMinus = 8'h2D;
    localparam logic [7:0]     ChZero  = 8'h30;
    localparam logic [7:0]     ChNine  = 8'h39;
    localparam logic [MagW-1:0] MagSat = 17'h10000;

    typedef logic signed [FieldW-1:0] field_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_COMMA,
        PH_MINUS,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic                        ok;
        field_t [MaxFields-1:0]      fields;
    } line_sum_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = ChA;
            3'd1:    ch = ChI;
            3'd2:    ch = ChM;
            default: ch = ChComma;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] sat_s16(input field_t v);
        logic [15:0] r;
        if (v < -18'sd32768) begin
            r = 16'h8000;
        end else if (v > 18'sd32767) begin
            r = 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_u16(input field_t v);
        logic [15:0] r;
        if (v <= 18'sd0) begin
            r = 16'h0000;
        end else if (v > 18'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### sv/alfp_scan.sv
module alfp_scan import alfp_pkg::*; #(
    parameter int FIELD_COUNT = 7
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      beat_fire,
    input  logic [7:0] char_code,
    input  logic      line_end,
    output line_sum_t line_sum
);

    localparam logic [3:0] FieldCnt = 4'(FIELD_COUNT);

    logic [2:0]      prefix_reg, prefix_next;
    logic [2:0]      fn_reg, fn_next;
    phase_t          phase_reg, phase_next;
    logic            minus_reg, minus_next;
    logic [MagW-1:0] mag_reg, mag_next;
    logic            failed_reg, failed_next;

    logic            is_digit;
    logic [20:0]     acc;
    logic [MagW-1:0] acc_sat;
    field_t          cur_val;
    logic            prefix_done;
    logic            fields_done;
    logic            last_field;
    logic            end_fin;
    logic            close_fld;
    logic            wr_en;
    phase_t          eff_phase;
    logic            eff_minus;
    field_t [MaxFields-1:0] fld_w;

    assign is_digit    = (char_code >= ChZero) && (char_code <= ChNine);
    assign acc         = 21'({mag_reg, 3'b000}) + 21'({mag_reg, 1'b0}) + 21'(char_code[3:0]);
    assign acc_sat     = (acc > 21'(MagSat)) ? MagSat : acc[MagW-1:0];
    assign cur_val     = minus_reg ? -field_t'({1'b0, mag_reg}) : field_t'({1'b0, mag_reg});
    assign prefix_done = (prefix_reg == 3'(PrefixLen));
    assign fields_done = ({1'b0, fn_reg} >= FieldCnt);
    assign last_field  = (({1'b0, fn_reg} + 4'd1) == FieldCnt);
    assign end_fin     = !failed_reg && prefix_done && (phase_reg == PH_DIGITS) && last_field;

    // non-digit after digits closes the field; unless that was the last field, the same char then opens the next one
    assign close_fld = beat_fire && !line_end && !failed_reg && prefix_done && !fields_done &&
                       (phase_reg == PH_DIGITS) && !is_digit;
    assign wr_en     = close_fld || (beat_fire && line_end && end_fin);

    always_comb begin
        prefix_next = prefix_reg;
        fn_next     = fn_reg;
        phase_next  = phase_reg;
        minus_next  = minus_reg;
        mag_next    = mag_reg;
        failed_next = failed_reg;
        eff_phase   = phase_reg;
        eff_minus   = minus_reg;
        if (beat_fire) begin
            if (line_end) begin
                prefix_next = '0;
                fn_next     = '0;
                phase_next  = PH_START;
                minus_next  = 1'b0;
                mag_next    = '0;
                failed_next = 1'b0;
            end else if (!failed_reg) begin
                if (!prefix_done) begin
                    if (char_code == prefix_char(prefix_reg)) begin
                        prefix_next = prefix_reg + 3'd1;
                    end else begin
                        failed_next = 1'b1;
                    end
                end else if (!fields_done) begin
                    if (phase_reg == PH_DIGITS && is_digit) begin
                        mag_next = acc_sat;
                    end else begin
                        if (close_fld) begin
                            fn_next    = fn_reg + 3'd1;
                            phase_next = PH_START;
                            minus_next = 1'b0;
                            mag_next   = '0;
                            eff_phase  = PH_START;
                            eff_minus  = 1'b0;
                        end
                        if (!(close_fld && last_field)) begin
                            if (is_digit) begin
                                phase_next = PH_DIGITS;
                                minus_next = eff_minus;
                                mag_next   = MagW'(char_code[3:0]);
                            end else if (char_code == ChMinus &&
                                         (eff_phase == PH_START || eff_phase == PH_COMMA)) begin
                                phase_next = PH_MINUS;
                                minus_next = 1'b1;
                            end else if (char_code == ChComma && eff_phase == PH_START) begin
                                phase_next = PH_COMMA;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            fn_reg     <= '0;
            phase_reg  <= PH_START;
            minus_reg  <= 1'b0;
            mag_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            prefix_reg <= prefix_next;
            fn_reg     <= fn_next;
            phase_reg  <= phase_next;
            minus_reg  <= minus_next;
            mag_reg    <= mag_next;
            failed_reg <= failed_next;
        end
    end

    for (genvar i = 0; i < MaxFields; i++) begin : g_fld
        if (i < FIELD_COUNT) begin : g_on
            field_t store_reg;
            always_ff @(posedge aclk) begin
                if (wr_en && fn_reg == 3'(i)) begin
                    store_reg <= cur_val;
                end
            end
            assign fld_w[i] = (end_fin && fn_reg == 3'(i)) ? cur_val : store_reg;
        end else begin : g_off
            assign fld_w[i] = '0;
        end
    end

    assign line_sum.ok     = !failed_reg && prefix_done && (({1'b0, fn_reg} == FieldCnt) || end_fin);
    assign line_sum.fields = fld_w;

endmodule

### sv/aim_line_field_parser_core.sv
// AIM line field parser.
// Input channel (s_): one text character per beat in s_tdata[7:0]; a beat with
// s_tlast high ends the line, its data byte is ignored.
// Result channel (m_): one beat per line, issued for every s_tlast beat.
// m_tuser is the ok flag; when it is low every m_tdata bit is zero.
// Lines must open with "AIM," followed by FIELD_COUNT decimal integers,
// each with an optional leading comma and minus sign.
// Throughput: one input beat per cycle, including line ends, while no result is stalled.
// The result is registered: m_tvalid rises in the cycle after the s_tlast beat is accepted.
// The scan state closes the per-character loop: one multiply-by-ten add and a few compares.
// Stall: when m_tready is low with a result held, s_tready drops until the
// result is taken; a result taken in the same cycle frees the register.
// Reset (aresetn low, synchronous): the line state clears and no result is
// pending; the stored field values are overwritten before use.
module aim_line_field_parser_core import alfp_pkg::*; #(
    parameter int FIELD_COUNT = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] char_code
    input  logic             s_tlast,   // line_end
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [DataW-1:0] m_tdata,   // aim_live, aim_dx, aim_dy, tgt_x, tgt_y,
                                        // laser_x, laser_y, tgt_seen, lsr_seen, zero pad
    output logic             m_tuser    // ok
);

    logic             s_fire;
    line_sum_t        line_sum;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [DataW-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;
    logic [15:0]      dx, dy, tx, ty, lx, ly;
    logic             aim_live, tgt_seen, lsr_seen;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    alfp_scan #(
        .FIELD_COUNT(FIELD_COUNT)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (s_fire),
        .char_code (s_tdata),
        .line_end  (s_tlast),
        .line_sum  (line_sum)
    );

    assign aim_live = (line_sum.fields[0] != '0);
    assign dx       = sat_s16(line_sum.fields[1]);
    assign dy       = sat_s16(line_sum.fields[2]);
    assign tx       = sat_u16(line_sum.fields[3]);
    assign ty       = sat_u16(line_sum.fields[4]);
    assign lx       = sat_u16(line_sum.fields[5]);
    assign ly       = sat_u16(line_sum.fields[6]);
    assign tgt_seen = (tx != '0) || (ty != '0);
    assign lsr_seen = (lx != '0) || (ly != '0);

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_fire && s_tlast) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = line_sum.ok;
            if (line_sum.ok) begin
                m_tdata_next = {5'b0, lsr_seen, tgt_seen, ly, lx, ty, tx, dy, dx, aim_live};
            end else begin
                m_tdata_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sv/alfp_chk.sv
module alfp_chk import alfp_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [7:0]       s_tdata,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [DataW-1:0] m_tdata,
    input logic             m_tuser
);

    a_line_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("line end beat gave no result");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed line with nonzero data");

    a_presence: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[97] == (m_tdata[64:33] != '0)) &&
                     (m_tdata[98] == (m_tdata[96:65] != '0)))
        else $error("presence flags disagree with coordinates");

endmodule

bind aim_line_field_parser_core alfp_chk u_alfp_chk (.*);

### test/tb.sv
module tb;
    import alfp_pkg::*;

    localparam int NFIELDS = 7;

    typedef struct packed {
        logic [4:0]  pad;
        logic        lsr_seen;
        logic        tgt_seen;
        logic [15:0] laser_y;
        logic [15:0] laser_x;
        logic [15:0] tgt_y;
        logic [15:0] tgt_x;
        logic [15:0] aim_dy;
        logic [15:0] aim_dx;
        logic        aim_live;
    } aim_fields_t;

    typedef struct {
        logic        ok;
        aim_fields_t f;
    } aim_line_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;
    } char_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'h00;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [DataW-1:0] m_tdata;
    logic             m_tuser;

    aim_line_field_parser_core #(.FIELD_COUNT(NFIELDS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // line scanner state
    int     pfx_len;
    int     fld_num;
    phase_t phase;
    bit     neg;
    int     mag;
    bit     failed;
    int     fld_val [NFIELDS];

    char_beat_t char_queue [$];
    aim_line_t  lines_due [$];
    logic [7:0] line_buf [$];
    int         mismatches = 0;
    int         src_gap = 0;
    int         sink_gap = 0;
    bit         src_burst = 0;
    bit         sink_burst = 0;
    aim_fields_t got_f;
    aim_line_t   want;
    char_beat_t  nxt;

    function automatic logic [7:0] lead_char(int pos);
        case (pos)
            0:       return ChA;
            1:       return ChI;
            2:       return ChM;
            default: return ChComma;
        endcase
    endfunction

    function automatic void clear_scan();
        pfx_len = 0;
        fld_num = 0;
        phase   = PH_START;
        neg     = 0;
        mag     = 0;
        failed  = 0;
    endfunction

    function automatic void store_field();
        int v;
        v = neg ? -mag : mag;
        if (fld_num < NFIELDS) fld_val[fld_num] = v;
        fld_num++;
        phase = PH_START;
        neg   = 0;
        mag   = 0;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        bit dig;
        dig = (c >= ChZero) && (c <= ChNine);
        if (pfx_len < PrefixLen) begin
            if (c == lead_char(pfx_len)) pfx_len++;
            else failed = 1;
            return;
        end
        if (fld_num >= NFIELDS) return;
        if (phase == PH_DIGITS) begin
            if (dig) begin
                mag = mag * 10 + int'(c - ChZero);
                if (mag > 65536) mag = 65536;
                return;
            end
            store_field();
            if (fld_num >= NFIELDS) return;
        end
        if (dig) begin
            phase = PH_DIGITS;
            mag   = int'(c - ChZero);
        end else if (c == ChMinus && (phase == PH_START || phase == PH_COMMA)) begin
            phase = PH_MINUS;
            neg   = 1;
        end else if (c == ChComma && phase == PH_START) begin
            phase = PH_COMMA;
        end else begin
            failed = 1;
        end
    endfunction

    function automatic logic [15:0] clamp_s16(int v);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clip_u16(int v);
        if (v <= 0) return 16'h0000;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic aim_line_t close_line();
        aim_line_t r;
        r.ok = 1'b0;
        r.f  = '0;
        if (!failed && pfx_len == PrefixLen && phase == PH_DIGITS && fld_num + 1 == NFIELDS)
            store_field();
        if (!failed && pfx_len == PrefixLen && fld_num == NFIELDS) begin
            r.ok         = 1'b1;
            r.f.aim_live = (fld_val[0] != 0);
            r.f.aim_dx   = clamp_s16(fld_val[1]);
            r.f.aim_dy   = clamp_s16(fld_val[2]);
            r.f.tgt_x    = clip_u16(fld_val[3]);
            r.f.tgt_y    = clip_u16(fld_val[4]);
            r.f.laser_x  = clip_u16(fld_val[5]);
            r.f.laser_y  = clip_u16(fld_val[6]);
            r.f.tgt_seen = (r.f.tgt_x != 0) || (r.f.tgt_y != 0);
            r.f.lsr_seen = (r.f.laser_x != 0) || (r.f.laser_y != 0);
        end
        clear_scan();
        return r;
    endfunction

    function automatic void take_beat(logic [7:0] c, logic last);
        if (last) lines_due.push_back(close_line());
        else if (!failed) scan_char(c);
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $realtime, name, exp_v, act_v);
        end
    endfunction

    // mostly short gaps, a few long ones; burst mode gives stretches with none
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) take_beat(s_tdata, s_tlast);
            if ($urandom_range(0, 149) == 0) src_burst = ~src_burst;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (char_queue.size() != 0 &&
                         !(char_queue[0].hold && lines_due.size() != 0)) begin
                nxt = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tlast  <= nxt.last;
                src_gap  = pick_gap(src_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_f = m_tdata;
                if (lines_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with none expected, ok %b data %h",
                                 $realtime, m_tuser, m_tdata);
                end else begin
                    want = lines_due.pop_front();
                    check_field("ok", 16'(want.ok), 16'(m_tuser));
                    check_field("aim_live", 16'(want.f.aim_live), 16'(got_f.aim_live));
                    check_field("aim_dx", want.f.aim_dx, got_f.aim_dx);
                    check_field("aim_dy", want.f.aim_dy, got_f.aim_dy);
                    check_field("tgt_x", want.f.tgt_x, got_f.tgt_x);
                    check_field("tgt_y", want.f.tgt_y, got_f.tgt_y);
                    check_field("laser_x", want.f.laser_x, got_f.laser_x);
                    check_field("laser_y", want.f.laser_y, got_f.laser_y);
                    check_field("tgt_seen", 16'(want.f.tgt_seen), 16'(got_f.tgt_seen));
                    check_field("lsr_seen", 16'(want.f.lsr_seen), 16'(got_f.lsr_seen));
                    check_field("pad", 16'(want.f.pad), 16'(got_f.pad));
                end
            end
            if ($urandom_range(0, 149) == 0) sink_burst = ~sink_burst;
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap(sink_burst);
            end
        end
    end

    task automatic buf_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic buf_num();
        int    cls;
        int    n;
        string s;
        cls = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 3) line_buf.push_back(ChMinus);
        if (cls < 3) begin
            s = $sformatf("%0d", $urandom_range(0, 9));
        end else if (cls < 6) begin
            s = $sformatf("%0d", $urandom_range(0, 999));
        end else if (cls < 8) begin
            s = $sformatf("%0d", $urandom_range(0, 70000));
        end else if (cls < 9) begin
            s = $sformatf("%0d", $urandom_range(0, 99));
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) line_buf.push_back(ChZero);
        end else begin
            n = $urandom_range(5, 12);
            s = "";
            for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        buf_str(s);
    endtask

    // moves the buffered line plus its terminator beat to the send queue
    task automatic flush_line(bit hold);
        char_beat_t b;
        b.hold = hold;
        while (line_buf.size() != 0) begin
            b.ch   = line_buf.pop_front();
            b.last = 1'b0;
            char_queue.push_back(b);
            b.hold = 0;
        end
        b.ch   = 8'($urandom_range(0, 255));
        b.last = 1'b1;
        char_queue.push_back(b);
    endtask

    initial begin
        int kind;
        int n_chars;
        int base;
        int pos;
        int len;

        clear_scan();
        for (int i = 0; i < NFIELDS; i++) fld_val[i] = 0;

        buf_str("AIM,1,-5,7,100,200,300,400");        flush_line(0);
        buf_str("AIM,0,-99999,99999,-3,70000,0,65535"); flush_line(0);
        buf_str("AIM,9,32767,-32768,65535,65536,1,0");  flush_line(0);
        buf_str("AIM,-0,-0,-0,-0,0,0,-0");              flush_line(0);
        buf_str("AIM,1-2-3-4-5-6-7");                   flush_line(0);
        buf_str("AIM,,1,2,3,4,5,6,7");                  flush_line(0);
        buf_str("AIM,,,1,2,3,4,5,6,7");                 flush_line(0);
        buf_str("AIM,123456789012,-98765432109,1,2,3,4,5"); flush_line(0);
        buf_str("AIM,1,2,3,4,5,6,7xyz,9");              flush_line(0);
        buf_str("AIM,1,2,3");                           flush_line(0);
        flush_line(0);
        buf_str("AIX,1,2,3,4,5,6,7");                   flush_line(0);
        buf_str("AIM,1,2,3,4,5,6,");                    flush_line(0);
        buf_str("AIM,-,1,2,3,4,5,6");                   flush_line(0);
        buf_str("AIM,--1,2,3,4,5,6,7");                 flush_line(0);
        buf_str("AIM,1,2,3,4,5,6,-");                   flush_line(0);
        buf_str("AIM,1,2");
        line_buf.push_back(8'h00);
        buf_str(",3,4,5,6,7");                          flush_line(0);
        buf_str("AIM,1,2,3,4,5,6,7");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);                      flush_line(0);

        base    = char_queue.size();
        n_chars = 0;
        while (base + n_chars < 1250) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                buf_str("AIM,");
                for (int f = 0; f < NFIELDS; f++) begin
                    if ($urandom_range(0, 4) != 0) line_buf.push_back(ChComma);
                    buf_num();
                end
                if ($urandom_range(0, 6) == 0) begin
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end
                if (kind >= 70 && line_buf.size() != 0) begin
                    pos = $urandom_range(0, line_buf.size() - 1);
                    case ($urandom_range(0, 3))
                        0: line_buf[pos] = 8'($urandom_range(0, 255));
                        1: line_buf.delete(pos);
                        2: line_buf.insert(pos, ($urandom_range(0, 1) != 0) ? ChComma : ChMinus);
                        default: begin
                            while (line_buf.size() > pos) void'(line_buf.pop_back());
                        end
                    endcase
                end
                n_chars += line_buf.size() + 1;
            end else if (kind < 95) begin
                if ($urandom_range(0, 1) != 0) buf_str("AIM,");
                len = $urandom_range(0, 12);
                for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
                n_chars += line_buf.size() + 1;
            end else if (kind < 98) begin
                n_chars += 1;
            end else begin
                buf_str("AIM,");
                n_chars += 5;
            end
            flush_line((n_chars < 40 && kind < 85) || $urandom_range(0, 39) == 0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid || lines_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && lines_due.size() == 0) begin
            $display("aim_line_field_parser_core: match");
        end else begin
            $display("aim_line_field_parser_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("aim_line_field_parser_core: mismatch");
        $finish;
    end

endmodule

### aim_line_field_parser_core.f
sv/alfp_pkg.sv
sv/alfp_scan.sv
sv/aim_line_field_parser_core.sv
sv/alfp_chk.sv
test/tb.sv
